// ===== design/pid_controller_trapezoidal_core_defines.svh =====
// assertion macros shared by the checker
`ifndef PID_CONTROLLER_TRAPEZOIDAL_CORE_DEFINES_SVH
`define PID_CONTROLLER_TRAPEZOIDAL_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PIDT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidt check failed");

// next-cycle implication, disabled in reset
`define PIDT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidt check failed");

// state seen in the cycle after reset
`define PIDT_ASSERT_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("pidt reset check failed");

`endif

// ===== design/pidt_pkg.sv =====
package pidt_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = 18;
  localparam int INTEG_W   = 48;
  localparam int ILO_W     = 24;
  localparam int DRIVE_W   = 32;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = 42;
  localparam int ACC_W     = 64;
  localparam int DIV_W     = 17;
  localparam int CNT_W     = 5;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = 16'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_DERIV_GAIN   = 2'd2,
    REG_TARGET_VALUE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MISC_NONE,
    MISC_CAPTURE,
    MISC_INTEG,
    MISC_DIV_INIT,
    MISC_DIV_STEP,
    MISC_DIV_FIX,
    MISC_OUTPUT
  } misc_op_t;

  typedef enum logic [2:0] {
    A_SUMERR,
    A_ERR,
    A_ILO,
    A_IHI,
    A_DERIV
  } asel_t;

  typedef enum logic [1:0] {
    B_DT,
    B_KP,
    B_KI,
    B_KD
  } bsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    misc_op_t misc;
    logic     mul_en;
    asel_t    asel;
    bsel_t    bsel;
    acc_op_t  acc;
    jmp_t     jmp;
    step_t    target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_blocked;
    logic div_more;
  } seq_status_t;

  // microprogram rom
  function automatic ctrl_word_t microcode(step_t s);
    ctrl_word_t w;
    w = '{misc: MISC_NONE, mul_en: 1'b0, asel: A_SUMERR, bsel: B_DT,
          acc: ACC_HOLD, jmp: JMP_NEXT, target: '0};
    unique case (s)
      4'd0: begin
        w.misc = MISC_CAPTURE;
        w.jmp  = JMP_WAIT_IN;
      end
      4'd1: begin
        w.misc   = MISC_DIV_INIT;
        w.mul_en = 1'b1;
        w.asel   = A_SUMERR;
        w.bsel   = B_DT;
      end
      4'd2: begin
        w.misc   = MISC_INTEG;
        w.mul_en = 1'b1;
        w.asel   = A_ERR;
        w.bsel   = B_KP;
      end
      4'd3: begin
        w.acc    = ACC_LOAD;
        w.mul_en = 1'b1;
        w.asel   = A_ILO;
        w.bsel   = B_KI;
      end
      4'd4: begin
        w.acc    = ACC_ADD;
        w.mul_en = 1'b1;
        w.asel   = A_IHI;
        w.bsel   = B_KI;
      end
      4'd5: begin
        w.acc  = ACC_ADD_HI;
        w.misc = MISC_DIV_STEP;
      end
      4'd6: begin
        w.misc   = MISC_DIV_STEP;
        w.jmp    = JMP_LOOP;
        w.target = 4'd6;
      end
      4'd7: begin
        w.misc = MISC_DIV_FIX;
      end
      4'd8: begin
        w.mul_en = 1'b1;
        w.asel   = A_DERIV;
        w.bsel   = B_KD;
      end
      4'd9: begin
        w.acc = ACC_ADD;
      end
      4'd10: begin
        w.misc   = MISC_OUTPUT;
        w.jmp    = JMP_WAIT_OUT;
        w.target = 4'd0;
      end
      default: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = 4'd0;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/pidt_sequencer.sv =====
module pidt_sequencer
  import pidt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctrl_word_t  ctrl
);

  step_t step;
  step_t step_next;

  assign ctrl = microcode(step);

  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEXT:     step_next = step + STEP_W'(1);
      JMP_WAIT_IN:  step_next = status.in_fire ? step + STEP_W'(1) : step;
      JMP_LOOP:     step_next = status.div_more ? ctrl.target : step + STEP_W'(1);
      JMP_WAIT_OUT: step_next = status.out_blocked ? step : ctrl.target;
      default:      step_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== design/pidt_datapath.sv =====
module pidt_datapath
  import pidt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_word_t                  ctrl,
  input  logic                        in_fire,
  input  logic signed [DATA_W-1:0]    measured,
  input  logic        [DATA_W-1:0]    time_step,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [GAIN_W-1:0]    cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [DRIVE_W-1:0]   drive,
  output logic                        saturated,
  output seq_status_t                 status
);

  localparam int HI_LSB = GAIN_FRAC_BITS + DRIVE_W - 1;

  logic signed [GAIN_W-1:0]  prop_gain;
  logic signed [GAIN_W-1:0]  integ_gain;
  logic signed [GAIN_W-1:0]  deriv_gain;
  logic signed [GAIN_W-1:0]  target_value;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_error;
  logic        [DATA_W-1:0]  dt;
  logic signed [INTEG_W-1:0] error_integral;
  logic                      sat_flag;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic        [DATA_W-1:0]  div_rem;
  logic        [DIV_W-1:0]   div_q;
  logic        [CNT_W-1:0]   div_cnt;
  logic                      div_neg;
  logic signed [SUM_W-1:0]   deriv;

  logic signed [ERR_W-1:0]   err_new;
  logic signed [SUM_W-1:0]   sum_err;
  logic signed [SUM_W-1:0]   diff_err;
  logic signed [SUM_W-1:0]   diff_abs;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_full;
  logic signed [PROD_W-1:0]  halved;
  logic signed [INTEG_W:0]   integ_sum;
  logic                      integ_clip;
  logic signed [ACC_W-1:0]   prod_ext;
  logic        [DIV_W-1:0]   trial;
  logic        [DIV_W-1:0]   trial_sub;
  logic                      trial_ge;
  logic signed [SUM_W-1:0]   quot;
  logic [ACC_W-HI_LSB-1:0]   acc_hi;
  logic                      drive_fits;
  logic                      out_load;

  assign err_new  = ERR_W'(target_value) - ERR_W'(measured);
  assign sum_err  = SUM_W'(err) + SUM_W'(last_error);
  assign diff_err = SUM_W'(err) - SUM_W'(last_error);
  assign diff_abs = diff_err[SUM_W-1] ? -diff_err : diff_err;

  always_comb begin
    case (ctrl.asel)
      A_SUMERR: mul_a = MUL_A_W'(sum_err);
      A_ERR:    mul_a = MUL_A_W'(err);
      A_ILO:    mul_a = $signed({1'b0, error_integral[ILO_W-1:0]});
      A_IHI:    mul_a = MUL_A_W'($signed(error_integral[INTEG_W-1:ILO_W]));
      A_DERIV:  mul_a = MUL_A_W'(deriv);
      default:  mul_a = '0;
    endcase
    case (ctrl.bsel)
      B_DT:    mul_b = $signed({1'b0, dt});
      B_KP:    mul_b = MUL_B_W'(prop_gain);
      B_KI:    mul_b = MUL_B_W'(integ_gain);
      B_KD:    mul_b = MUL_B_W'(deriv_gain);
      default: mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // halve toward zero, then add into the integral with clipping
  assign halved     = (prod + $signed({{(PROD_W-1){1'b0}}, prod[PROD_W-1]})) >>> 1;
  assign integ_sum  = (INTEG_W+1)'(error_integral) + (INTEG_W+1)'(halved);
  assign integ_clip = integ_sum[INTEG_W] != integ_sum[INTEG_W-1];

  assign prod_ext = ACC_W'(prod);

  // one restoring divide step
  assign trial     = {div_rem, div_q[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, dt};
  assign trial_sub = trial - {1'b0, dt};

  assign quot = $signed({1'b0, div_q});

  assign acc_hi     = acc[ACC_W-1:HI_LSB];
  assign drive_fits = (&acc_hi) | ~(|acc_hi);

  assign status.in_fire     = in_fire;
  assign status.out_blocked = out_valid && !out_ready;
  assign status.div_more    = div_cnt != '0;

  assign out_load = (ctrl.misc == MISC_OUTPUT) && !status.out_blocked;

  // config and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RESET;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      target_value   <= '0;
      last_error     <= '0;
      error_integral <= '0;
      div_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:    prop_gain    <= $signed(cfg_data);
          REG_INTEG_GAIN:   integ_gain   <= $signed(cfg_data);
          REG_DERIV_GAIN:   deriv_gain   <= $signed(cfg_data);
          REG_TARGET_VALUE: target_value <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (ctrl.misc == MISC_INTEG) begin
        error_integral <= integ_clip ?
          $signed({integ_sum[INTEG_W], {(INTEG_W-1){~integ_sum[INTEG_W]}}}) :
          integ_sum[INTEG_W-1:0];
      end
      if (ctrl.misc == MISC_DIV_INIT) begin
        div_cnt <= CNT_W'(DIV_W - 1);
      end else if (ctrl.misc == MISC_DIV_STEP && div_cnt != '0) begin
        div_cnt <= div_cnt - CNT_W'(1);
      end
      if (out_load) begin
        last_error <= err;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.misc == MISC_CAPTURE && in_fire) begin
      err      <= err_new;
      dt       <= time_step;
      sat_flag <= 1'b0;
    end
    if (ctrl.misc == MISC_INTEG) begin
      sat_flag <= integ_clip;
    end
    if (ctrl.mul_en) begin
      prod <= mul_full;
    end
    case (ctrl.acc)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_HI: acc <= acc + (prod_ext <<< ILO_W);
      default: ;
    endcase
    if (ctrl.misc == MISC_DIV_INIT) begin
      div_neg <= diff_err[SUM_W-1];
      div_q   <= diff_abs[DIV_W-1:0];
      div_rem <= '0;
    end
    if (ctrl.misc == MISC_DIV_STEP) begin
      div_rem <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      div_q   <= {div_q[DIV_W-2:0], trial_ge};
    end
    if (ctrl.misc == MISC_DIV_FIX) begin
      if (dt == '0) begin
        deriv <= '0;
      end else begin
        deriv <= div_neg ? -quot : quot;
      end
    end
    if (out_load) begin
      drive     <= drive_fits ? acc[GAIN_FRAC_BITS +: DRIVE_W] :
                   $signed({acc[ACC_W-1], {(DRIVE_W-1){~acc[ACC_W-1]}}});
      saturated <= sat_flag | ~drive_fits;
    end
  end

endmodule

// ===== design/pid_controller_trapezoidal_core.sv =====
// channel   dir  tdata fields (lsb first)                  tuser
// s_axis    in   measured[15:0], time_step[31:16]            -
// m_axis    out  drive[31:0], saturated[32], zero[39:33]     -
// cfg       in   cfg_we, cfg_index, cfg_data (gains, target) -
//
// one item at a time: accept, then 25 microcode steps, 17 of them
// in the bit-serial divider that forms the derivative
// reset sets prop_gain to 1.0, other gains, target, error and integral to 0
// the result register holds until taken; the next item is accepted meanwhile,
// and only the output step waits if the previous result is still there
module pid_controller_trapezoidal_core
  import pidt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // measured, time_step
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // drive, saturated, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data
);

  ctrl_word_t                ctrl;
  seq_status_t               status;
  logic                      in_fire;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;

  assign s_axis_tready = ctrl.misc == MISC_CAPTURE;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata = {{(OUT_DATA_W-DRIVE_W-1){1'b0}}, saturated, drive};

  pidt_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  pidt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .measured  ($signed(s_axis_tdata[DATA_W-1:0])),
    .time_step (s_axis_tdata[IN_DATA_W-1:DATA_W]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .drive     (drive),
    .saturated (saturated),
    .status    (status)
  );

endmodule

// ===== design/pidt_checker.sv =====
`include "pid_controller_trapezoidal_core_defines.svh"

module pidt_checker
  import pidt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // one item in flight
  `PIDT_ASSERT_NXT(busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `PIDT_ASSERT_NXT(out_held, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  `PIDT_ASSERT_NXT(out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // padding bits above the saturation flag
  `PIDT_ASSERT_IMP(pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:DRIVE_W+1] == '0)

  `PIDT_ASSERT_RST(idle_after_reset, clk, rst, s_axis_tready && !m_axis_tvalid)

endmodule

bind pid_controller_trapezoidal_core pidt_checker u_pidt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
